### hw/rtl/wmv_pkg.sv
package wmv_pkg;

  // fixed field widths of the sample and result transactions
  localparam int SAMPLE_FIELD_BITS = 24;
  localparam int MEAN_BITS         = 24;
  localparam int VAR_BITS          = 46;

  // configuration port
  localparam int WIN_BITS       = 7;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ACCEL_WINDOW    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POSITION_WINDOW = 1'b1;

  localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd32;

  // per-cycle commands from the sequencer to the axis lanes
  typedef struct packed {
    logic load;     // capture a new sample
    logic acc_sum;  // square the sample, add it into the running sum
    logic acc_sq;   // add the square into the running square sum
    logic close;    // form n*sumsq and sum^2, clear the stream
    logic sub;      // form n*sumsq - sum^2
    logic start;    // launch the dividers
    logic stream;   // stream the command applies to
  } wmv_lane_ctrl_t;

endpackage

### hw/rtl/wmv_div.sv
module wmv_div #(
  parameter int NUM_BITS = 32,
  parameter int DEN_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [NUM_BITS-1:0] quo,
  output logic [DEN_BITS-1:0] rem,
  output logic                done
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] quo_r;
  logic [DEN_BITS-1:0] rem_r;
  logic [DEN_BITS-1:0] den_r;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   trial_diff;
  logic                fits;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  assign trial      = {rem_r, quo_r[NUM_BITS-1]};
  assign trial_diff = trial - {1'b0, den_r};
  assign fits       = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= CW'(NUM_BITS);
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      quo_r <= {quo_r[NUM_BITS-2:0], fits};
      rem_r <= fits ? trial_diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      cnt   <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

### hw/rtl/wmv_lane.sv
module wmv_lane #(
  parameter int SAMPLE_BITS = 24,
  parameter int MAX_WINDOW  = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wmv_pkg::wmv_lane_ctrl_t             ctrl,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     n,
  input  logic [2*$clog2(MAX_WINDOW+1)-1:0]   nn,
  output logic signed [wmv_pkg::MEAN_BITS-1:0] mean,
  output logic [wmv_pkg::VAR_BITS-1:0]        variance,
  output logic                                done
);
  import wmv_pkg::*;

  localparam int CNTW = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int SQW  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_WINDOW);
  localparam int VNW  = 2 * SUMW;

  logic signed [SAMPLE_BITS-1:0]   sample_q;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic [2*SAMPLE_BITS-1:0]        square;
  logic signed [SUMW-1:0]          sum [2];
  logic [SQW-1:0]                  sq_sum [2];
  logic signed [SUMW-1:0]          cur_sum;
  logic [SUMW-1:0]                 mag_c;
  logic [SUMW-1:0]                 mag_q;
  logic                            neg_q;
  logic [CNTW+SQW-1:0]             lhs_c;
  logic [VNW-1:0]                  rhs_c;
  logic [VNW-1:0]                  lhs;
  logic [VNW-1:0]                  rhs;
  logic [VNW-1:0]                  diff;
  logic [SUMW-1:0]                 mean_quo;
  logic [CNTW-1:0]                 mean_rem;
  logic                            mean_done;
  logic [VNW-1:0]                  var_quo;
  logic [2*CNTW-1:0]               var_rem;
  logic                            var_done;
  logic [SUMW:0]                   q_up;
  logic signed [SUMW:0]            mean_full;
  logic                            var_sat;

  // square of the captured sample, magnitude of the open sum and the window-end products
  assign prod    = sample_q * sample_q;
  assign cur_sum = sum[ctrl.stream];
  assign mag_c   = cur_sum[SUMW-1] ? SUMW'(unsigned'(-cur_sum)) : SUMW'(unsigned'(cur_sum));
  assign lhs_c   = n * sq_sum[ctrl.stream];
  assign rhs_c   = mag_c * mag_c;

  // accumulators: add on acc_sum and acc_sq, clear the stream on close
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        sum[i]    <= '0;
        sq_sum[i] <= '0;
      end
    end else begin
      if (ctrl.acc_sum) begin
        sum[ctrl.stream] <= cur_sum + SUMW'(sample_q);
      end
      if (ctrl.acc_sq) begin
        sq_sum[ctrl.stream] <= sq_sum[ctrl.stream] + SQW'(square);
      end
      if (ctrl.close) begin
        sum[ctrl.stream]    <= '0;
        sq_sum[ctrl.stream] <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_q <= sample;
    end
    if (ctrl.acc_sum) begin
      square <= unsigned'(prod);
    end
    if (ctrl.close) begin
      lhs   <= VNW'(lhs_c);
      rhs   <= rhs_c;
      mag_q <= mag_c;
      neg_q <= cur_sum[SUMW-1];
    end
    if (ctrl.sub) begin
      diff <= (lhs > rhs) ? lhs - rhs : '0;
    end
  end

  wmv_div #(
    .NUM_BITS(SUMW),
    .DEN_BITS(CNTW)
  ) u_mean_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.start),
    .num   (mag_q),
    .den   (n),
    .quo   (mean_quo),
    .rem   (mean_rem),
    .done  (mean_done)
  );

  wmv_div #(
    .NUM_BITS(VNW),
    .DEN_BITS(2 * CNTW)
  ) u_var_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.start),
    .num   (diff),
    .den   (nn),
    .quo   (var_quo),
    .rem   (var_rem),
    .done  (var_done)
  );

  // floor division: a negative sum rounds its magnitude up
  assign q_up      = {1'b0, mean_quo} + {{SUMW{1'b0}}, (mean_rem != '0)};
  assign mean_full = neg_q ? -signed'(q_up) : signed'({1'b0, mean_quo});
  assign mean      = MEAN_BITS'(mean_full);

  // clamp to the result field
  assign var_sat  = (VNW > VAR_BITS) && ((var_quo >> VAR_BITS) != '0) && (var_rem == var_rem);
  assign variance = var_sat ? '1 : VAR_BITS'(var_quo);

  assign done = mean_done && var_done;

endmodule

### hw/rtl/windowed_mean_variance_3axis.sv
// Windowed mean and population variance of three-axis samples for two streams.
// Input channel (in_valid / in_stall): one Q12.12 sample per transaction, cmd
// selects the acceleration (0) or position (1) stream. Each stream counts its
// own samples; when the count reaches that stream's window register the block
// emits one result transaction (out_valid / out_stall) with per-axis floor
// means and floored population variances, then clears that stream.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the window
// lengths; cfg_ready is always high. Write only while the block is idle.
// Sequence: a sample that does not close a window occupies the block through the
// square and accumulate states. A closing sample also passes the multiply,
// subtract, start and divide states, the divide state set by the bit-per-cycle
// variance divider in each of the three axis lanes; the lanes run side by side.
// Its result then waits in the output state until the output register is free.
// The result sits in an output register: while out_stall is high it holds,
// and the block keeps taking samples; a further window end waits for it.
// Reset (rst, synchronous) clears counts, sums and the output valid, and sets
// both windows to 32.
module windowed_mean_variance_3axis #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic                                          cmd,
  input  logic signed [wmv_pkg::SAMPLE_FIELD_BITS-1:0]  sample_x,
  input  logic signed [wmv_pkg::SAMPLE_FIELD_BITS-1:0]  sample_y,
  input  logic signed [wmv_pkg::SAMPLE_FIELD_BITS-1:0]  sample_z,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic                                          stream_id,
  output logic signed [wmv_pkg::MEAN_BITS-1:0]          mean_x,
  output logic signed [wmv_pkg::MEAN_BITS-1:0]          mean_y,
  output logic signed [wmv_pkg::MEAN_BITS-1:0]          mean_z,
  output logic [wmv_pkg::VAR_BITS-1:0]                  variance_x,
  output logic [wmv_pkg::VAR_BITS-1:0]                  variance_y,
  output logic [wmv_pkg::VAR_BITS-1:0]                  variance_z,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [wmv_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
  input  logic [wmv_pkg::WIN_BITS-1:0]                  cfg_data
);
  import wmv_pkg::*;

  localparam int CNTW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_MUL,
    S_SUB,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  state_t               state;
  logic                 stream;
  logic [CNTW-1:0]      count [2];
  logic [CNTW-1:0]      n;
  logic [2*CNTW-1:0]    nn;
  logic [WIN_BITS-1:0]  accel_window;
  logic [WIN_BITS-1:0]  position_window;
  logic [WIN_BITS-1:0]  win_raw;
  logic [CNTW-1:0]      win_eff;
  logic [CNTW-1:0]      cur_count;
  logic                 in_take;
  logic                 out_free;
  wmv_lane_ctrl_t       ctrl;

  logic signed [SAMPLE_BITS-1:0] lane_sample [3];
  logic signed [MEAN_BITS-1:0]   lane_mean [3];
  logic [VAR_BITS-1:0]           lane_var [3];
  logic [2:0]                    lane_done;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // window of the stream being worked on: zero means one, clamp at the maximum
  assign win_raw   = stream ? position_window : accel_window;
  assign cur_count = count[stream];

  always_comb begin
    if (win_raw == '0) begin
      win_eff = CNTW'(1);
    end else if (32'(win_raw) > 32'(MAX_WINDOW)) begin
      win_eff = CNTW'(MAX_WINDOW);
    end else begin
      win_eff = CNTW'(win_raw);
    end
  end

  // lane commands decoded from the sequencer state
  always_comb begin
    ctrl         = '0;
    ctrl.stream  = stream;
    ctrl.load    = in_take;
    ctrl.acc_sum = (state == S_SQUARE);
    ctrl.acc_sq  = (state == S_ACCUM);
    ctrl.close   = (state == S_MUL);
    ctrl.sub     = (state == S_SUB);
    ctrl.start   = (state == S_START);
  end

  // low SAMPLE_BITS of each field, taken as signed
  assign lane_sample[0] = signed'(sample_x[SAMPLE_BITS-1:0]);
  assign lane_sample[1] = signed'(sample_y[SAMPLE_BITS-1:0]);
  assign lane_sample[2] = signed'(sample_z[SAMPLE_BITS-1:0]);

  for (genvar a = 0; a < 3; a++) begin : g_lane
    wmv_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_WINDOW (MAX_WINDOW)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sample   (lane_sample[a]),
      .n        (n),
      .nn       (nn),
      .mean     (lane_mean[a]),
      .variance (lane_var[a]),
      .done     (lane_done[a])
    );
  end

  // sequencer, counts, window registers and the merged output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      count[0]        <= '0;
      count[1]        <= '0;
      accel_window    <= WIN_RESET;
      position_window <= WIN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ACCEL_WINDOW:    accel_window    <= cfg_data;
          REG_POSITION_WINDOW: position_window <= cfg_data;
        endcase
      end

      // result valid: load a finished window, drop an accepted one
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            stream <= cmd;
            state  <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          count[stream] <= cur_count + CNTW'(1);
          state         <= S_ACCUM;
        end
        S_ACCUM: begin
          if (cur_count >= win_eff) begin
            n             <= cur_count;
            nn            <= cur_count * cur_count;
            count[stream] <= '0;
            state         <= S_MUL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MUL:   state <= S_SUB;
        S_SUB:   state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (&lane_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            stream_id  <= stream;
            mean_x     <= lane_mean[0];
            mean_y     <= lane_mean[1];
            mean_z     <= lane_mean[2];
            variance_x <= lane_var[0];
            variance_y <= lane_var[1];
            variance_z <= lane_var[2];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/wmv_checker.sv
module wmv_assertions (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          in_valid,
  input logic                                          in_stall,
  input logic                                          cmd,
  input logic signed [wmv_pkg::SAMPLE_FIELD_BITS-1:0]  sample_x,
  input logic signed [wmv_pkg::SAMPLE_FIELD_BITS-1:0]  sample_y,
  input logic signed [wmv_pkg::SAMPLE_FIELD_BITS-1:0]  sample_z,
  input logic                                          out_valid,
  input logic                                          out_stall,
  input logic                                          stream_id,
  input logic signed [wmv_pkg::MEAN_BITS-1:0]          mean_x,
  input logic signed [wmv_pkg::MEAN_BITS-1:0]          mean_y,
  input logic signed [wmv_pkg::MEAN_BITS-1:0]          mean_z,
  input logic [wmv_pkg::VAR_BITS-1:0]                  variance_x,
  input logic [wmv_pkg::VAR_BITS-1:0]                  variance_y,
  input logic [wmv_pkg::VAR_BITS-1:0]                  variance_z,
  input logic                                          cfg_valid,
  input logic                                          cfg_ready,
  input logic [wmv_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
  input logic [wmv_pkg::WIN_BITS-1:0]                  cfg_data
);
  import wmv_pkg::*;

  // a stalled result transaction holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(stream_id) && $stable(mean_x)
      && $stable(mean_y) && $stable(mean_z) && $stable(variance_x)
      && $stable(variance_y) && $stable(variance_z))
    else $error("stalled result changed");

  // one sample at a time: the block is busy right after taking one
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in progress");

  // a new result only comes out of a busy period
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // reset drops any pending result
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind windowed_mean_variance_3axis wmv_assertions u_checker (.*);
